// File: src/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int ID_W             = 32;
   localparam int SAMPLE_W         = 16;
   localparam int DURATION_W       = 16;
   localparam int CMD_W            = 3;
   localparam int STATUS_W         = 3;
   localparam int INDEX_W          = 5;
   localparam int COUNT_OUT_W      = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER   = 3'd0,
      CMD_UNREGISTER = 3'd1,
      CMD_ADD_DATA   = 3'd2,
      CMD_FLUSH      = 3'd3,
      CMD_READ_ENTRY = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ROW    = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic latch;        // capture request fields
      logic exec;         // run the command against the tables
      logic load_row;     // put one row into the response register
      logic load_status;  // put the status transfer into the response register
   } dsa_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic flush_go;     // valid during exec: rows follow
      logic last_row;     // row counter points at the last entry
      logic out_free;     // response register can take a transfer
   } dsa_sts_type;

endpackage

`default_nettype wire

// File: src/dsa_ctrl.sv
`default_nettype none

module dsa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dsa_pkg::dsa_sts_type sts,
   output dsa_pkg::dsa_ctl_type      ctl
);
   import dsa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_ROWS,
      S_STATUS
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      ctl.latch       = 1'b0;
      ctl.exec        = 1'b0;
      ctl.load_row    = 1'b0;
      ctl.load_status = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.flush_go ? S_ROWS : S_STATUS;
         end
         S_ROWS: begin
            ctl.load_row = sts.out_free;
            if (sts.out_free && sts.last_row) begin
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            // next request may enter while the status goes out
            req_ready       = sts.out_free;
            ctl.load_status = sts.out_free;
            if (sts.out_free) begin
               ctl.latch = req_valid;
               state_in  = req_valid ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/dsa_datapath.sv
`default_nettype none

module dsa_datapath #(
   parameter int CAPACITY = dsa_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dsa_pkg::dsa_ctl_type                ctl,
   output dsa_pkg::dsa_sts_type                     sts,
   input  wire logic [dsa_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [dsa_pkg::ID_W-1:0]            req_device_id,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_temp,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_current,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_voltage,
   input  wire logic [dsa_pkg::INDEX_W-1:0]         req_index,
   input  wire logic                                csr_wr_en,
   input  wire logic [dsa_pkg::DURATION_W-1:0]      csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_kind,
   output logic                                     rsp_last,
   output logic [dsa_pkg::STATUS_W-1:0]             rsp_status,
   output logic [dsa_pkg::COUNT_OUT_W-1:0]          rsp_missing_count,
   output logic [dsa_pkg::COUNT_OUT_W-1:0]          rsp_entry_count,
   output logic [dsa_pkg::INDEX_W-1:0]              rsp_row_slot,
   output logic [dsa_pkg::ID_W-1:0]                 rsp_out_id,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_temp,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_current,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_voltage,
   output logic                                     rsp_new_file
);
   import dsa_pkg::*;

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // latched request
   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SAMPLE_W-1:0] temp_ff, current_ff, voltage_ff;
   logic [INDEX_W-1:0]  index_ff;

   // tables and bookkeeping
   logic [ID_W-1:0]     id_table_ff   [CAPACITY];
   logic [SAMPLE_W-1:0] temp_tab_ff   [CAPACITY];
   logic [SAMPLE_W-1:0] curr_tab_ff   [CAPACITY];
   logic [SAMPLE_W-1:0] volt_tab_ff   [CAPACITY];
   logic [CAPACITY-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]    entries_ff, entries_in;
   logic [CNT_W-1:0]    reported_ff, reported_in;
   logic [DURATION_W-1:0] rows_ff, rows_in;
   logic [DURATION_W-1:0] duration_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   // status held for the closing transfer
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic                newf_ff, newf_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_last_ff, rsp_new_file_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_missing_ff, rsp_entries_ff;
   logic [INDEX_W-1:0]  rsp_slot_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [SAMPLE_W-1:0] rsp_temp_ff, rsp_current_ff, rsp_voltage_ff;

   // lookup
   logic [CAPACITY-1:0] hit;
   logic                found;
   logic [SLOT_W-1:0]   pos;
   logic [CNT_W-1:0]    last_cnt;
   logic [SLOT_W-1:0]   last_slot;
   logic [SLOT_W-1:0]   rd_slot;
   logic [ID_W-1:0]     rd_id;
   logic                idx_in_range;

   // table write port
   logic                id_we;
   logic [SLOT_W-1:0]   id_wa;
   logic [ID_W-1:0]     id_wd;
   logic                smp_we;

   logic [DURATION_W-1:0] rows_plus;
   logic                do_flush;
   logic [CNT_W-1:0]    missing;

   always_comb begin
      hit = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i] = (CNT_W'(i) < entries_ff) && (id_table_ff[i] == id_ff);
      end
   end

   always_comb begin
      pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pos = SLOT_W'(i);
         end
      end
   end

   assign found        = |hit;
   assign last_cnt     = entries_ff - CNT_W'(1);
   assign last_slot    = last_cnt[SLOT_W-1:0];
   assign idx_in_range = {1'b0, index_ff} < COUNT_OUT_W'(entries_ff);
   assign rows_plus    = rows_ff + DURATION_W'(1);
   assign missing      = entries_ff - reported_ff;

   // single read port on the id table
   always_comb begin
      if (ctl.exec && cmd_ff == CMD_UNREGISTER) begin
         rd_slot = last_slot;
      end else if (ctl.exec) begin
         rd_slot = index_ff[SLOT_W-1:0];
      end else begin
         rd_slot = slot_ff;
      end
   end
   assign rd_id = id_table_ff[rd_slot];

   always_comb begin
      mask_in     = mask_ff;
      entries_in  = entries_ff;
      reported_in = reported_ff;
      rows_in     = rows_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      rid_in      = rid_ff;
      newf_in     = newf_ff;
      id_we       = 1'b0;
      id_wa       = pos;
      id_wd       = id_ff;
      smp_we      = 1'b0;
      do_flush    = 1'b0;

      if (ctl.exec) begin
         status_in = ST_OK;
         rid_in    = '0;
         newf_in   = 1'b0;
         slot_in   = '0;
         case (cmd_ff)
            CMD_REGISTER: begin
               mask_in     = '0;
               reported_in = '0;
               if (found) begin
                  status_in = ST_DUPLICATE;
               end else if (entries_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  id_we      = 1'b1;
                  id_wa      = entries_ff[SLOT_W-1:0];
                  entries_in = entries_ff + CNT_W'(1);
               end
            end
            CMD_UNREGISTER: begin
               mask_in     = '0;
               reported_in = '0;
               if (found) begin
                  // last entry's id fills the freed slot
                  id_we      = 1'b1;
                  id_wa      = pos;
                  id_wd      = rd_id;
                  entries_in = last_cnt;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            CMD_ADD_DATA: begin
               if (found) begin
                  smp_we       = 1'b1;
                  mask_in[pos] = 1'b1;
                  if (!mask_ff[pos]) begin
                     reported_in = reported_ff + CNT_W'(1);
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
               do_flush = (reported_in == entries_ff) && (mask_in != '0);
            end
            CMD_FLUSH: begin
               do_flush = (mask_ff != '0);
            end
            CMD_READ_ENTRY: begin
               if (idx_in_range) begin
                  rid_in = rd_id;
               end else begin
                  status_in = ST_RANGE;
                  rid_in    = '1;
               end
            end
            default: ;
         endcase

         if (do_flush) begin
            mask_in     = '0;
            reported_in = '0;
            if (duration_ff != '0 && rows_plus == duration_ff) begin
               newf_in = 1'b1;
               rows_in = '0;
            end else begin
               rows_in = rows_plus;
            end
         end
      end else if (ctl.load_row) begin
         slot_in = slot_ff + SLOT_W'(1);
      end
   end

   assign sts.flush_go = do_flush;
   assign sts.last_row = (slot_ff == last_slot);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_row || ctl.load_status) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= '0;
         reported_ff  <= '0;
         mask_ff      <= '0;
         rows_ff      <= '0;
         duration_ff  <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            temp_tab_ff[i] <= '0;
            curr_tab_ff[i] <= '0;
            volt_tab_ff[i] <= '0;
         end
      end else begin
         entries_ff   <= entries_in;
         reported_ff  <= reported_in;
         mask_ff      <= mask_in;
         rows_ff      <= rows_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            duration_ff <= csr_wr_data;
         end
         if (smp_we) begin
            temp_tab_ff[pos] <= temp_ff;
            curr_tab_ff[pos] <= current_ff;
            volt_tab_ff[pos] <= voltage_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rid_ff    <= rid_in;
      newf_ff   <= newf_in;
      if (id_we) begin
         id_table_ff[id_wa] <= id_wd;
      end
      if (ctl.latch) begin
         cmd_ff     <= req_cmd;
         id_ff      <= req_device_id;
         temp_ff    <= req_temp;
         current_ff <= req_current;
         voltage_ff <= req_voltage;
         index_ff   <= req_index;
      end
      if (ctl.load_row) begin
         rsp_kind_ff     <= KIND_ROW;
         rsp_last_ff     <= 1'b0;
         rsp_status_ff   <= ST_OK;
         rsp_missing_ff  <= COUNT_OUT_W'(missing);
         rsp_entries_ff  <= COUNT_OUT_W'(entries_ff);
         rsp_slot_ff     <= INDEX_W'(slot_ff);
         rsp_id_ff       <= rd_id;
         rsp_temp_ff     <= temp_tab_ff[slot_ff];
         rsp_current_ff  <= curr_tab_ff[slot_ff];
         rsp_voltage_ff  <= volt_tab_ff[slot_ff];
         rsp_new_file_ff <= 1'b0;
      end else if (ctl.load_status) begin
         rsp_kind_ff     <= KIND_STATUS;
         rsp_last_ff     <= 1'b1;
         rsp_status_ff   <= status_ff;
         rsp_missing_ff  <= COUNT_OUT_W'(missing);
         rsp_entries_ff  <= COUNT_OUT_W'(entries_ff);
         rsp_slot_ff     <= '0;
         rsp_id_ff       <= rid_ff;
         rsp_temp_ff     <= '0;
         rsp_current_ff  <= '0;
         rsp_voltage_ff  <= '0;
         rsp_new_file_ff <= newf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_missing_count = rsp_missing_ff;
   assign rsp_entry_count   = rsp_entries_ff;
   assign rsp_row_slot      = rsp_slot_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_temp      = rsp_temp_ff;
   assign rsp_out_current   = rsp_current_ff;
   assign rsp_out_voltage   = rsp_voltage_ff;
   assign rsp_new_file      = rsp_new_file_ff;

endmodule

`default_nettype wire

// File: src/device_sample_aggregator.sv
// Device sample aggregator.
// Request channel (req_*, valid/ready): one command per transfer - register,
// unregister, add data, flush or read entry - with device id, sample and index.
// Response channel (rsp_*, valid/ready): zero or more row transfers (kind = 1,
// one per table entry, in slot order) followed by one status transfer
// (kind = 0, last = 1) for every request.
// csr_wr_en / csr_wr_data write file_duration at any edge; write it while idle.
// The request is latched on the request edge, the tables are updated in the exec
// state, and the response register is loaded with the status once it is free.
// Rows and status share the single response register, so a flush presents its
// rows one at a time, in slot order, ahead of the status. A new request is
// taken in the cycle its predecessor's status is loaded, so the response
// register decouples the two sides.
// Receiver stall: rsp_* hold while rsp_ready is low; rows and status wait, and
// req_ready stays low until the status transfer has a free register.
// Reset (synchronous, active high): table empty, samples zero, report mask
// and row count cleared, file_duration 0, no response pending.
`default_nettype none

module device_sample_aggregator #(
   parameter int CAPACITY = dsa_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dsa_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [dsa_pkg::ID_W-1:0]            req_device_id,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_temp,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_current,
   input  wire logic [dsa_pkg::SAMPLE_W-1:0]        req_voltage,
   input  wire logic [dsa_pkg::INDEX_W-1:0]         req_index,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_kind,
   output logic                                     rsp_last,
   output logic [dsa_pkg::STATUS_W-1:0]             rsp_status,
   output logic [dsa_pkg::COUNT_OUT_W-1:0]          rsp_missing_count,
   output logic [dsa_pkg::COUNT_OUT_W-1:0]          rsp_entry_count,
   output logic [dsa_pkg::INDEX_W-1:0]              rsp_row_slot,
   output logic [dsa_pkg::ID_W-1:0]                 rsp_out_id,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_temp,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_current,
   output logic [dsa_pkg::SAMPLE_W-1:0]             rsp_out_voltage,
   output logic                                     rsp_new_file,
   input  wire logic                                csr_wr_en,
   input  wire logic [dsa_pkg::DURATION_W-1:0]      csr_wr_data
);
   import dsa_pkg::*;

   // command / status between sequencer and datapath
   dsa_ctl_type ctl;
   dsa_sts_type sts;

   // sequencer: idle -> exec -> (rows) -> status
   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // tables, lookup, row counter and response register
   dsa_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_device_id     (req_device_id),
      .req_temp          (req_temp),
      .req_current       (req_current),
      .req_voltage       (req_voltage),
      .req_index         (req_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status),
      .rsp_missing_count (rsp_missing_count),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_row_slot      (rsp_row_slot),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_temp      (rsp_out_temp),
      .rsp_out_current   (rsp_out_current),
      .rsp_out_voltage   (rsp_out_voltage),
      .rsp_new_file      (rsp_new_file)
   );

endmodule

`default_nettype wire
